>>> hdl/assert_macros.svh
// Assertion macros for the radix digit emitter.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define RDE_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define RDE_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/rde_pkg.sv
// Shared types and constants for the radix digit emitter.
// No dependencies; imported by rde_out_if, rde_front, rde_back, the core and the sim files.
package rde_pkg;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_RADIX = 1'b0;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;
  localparam logic [4:0] RADIX_RST = 5'd16;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_F    = 8'h66;

  // Classified job flags that travel with each value through the queue.
  typedef struct packed {
    logic       bad;
    logic [4:0] radix;
  } rde_job_t;

  // One result word.
  typedef struct packed {
    logic [7:0] ascii_char;
    logic       final_char;
    logic       bad_radix;
  } rde_res_t;

endpackage

>>> hdl/rde_ifs.sv
// Valid/ready channel interfaces for values in and characters out.
// rde_out_if imports rde_pkg.
interface rde_in_if #(parameter int VALUE_BITS = 48) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface rde_out_if import rde_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       final_char;
  logic       bad_radix;

  modport source (output valid, output ascii_char, output final_char,
                  output bad_radix, input ready);
  modport sink (input valid, input ascii_char, input final_char,
                input bad_radix, output ready);
endinterface

>>> hdl/rde_front.sv
// Front end: takes value words, checks the base and hands jobs to the queue.
// Depends on rde_pkg and rde_in_if.
module rde_front import rde_pkg::*; #(
  parameter int VALUE_BITS = 48
) (
  rde_in_if.sink                items,
  input  logic [4:0]            radix,
  input  logic                  q_full,
  output logic                  q_push,
  output rde_job_t              q_job,
  output logic [VALUE_BITS-1:0] q_value
);

  assign items.ready = !q_full;
  assign q_push      = items.valid && !q_full;

  // Snapshot the base with the value; an out-of-range base becomes an error job.
  always_comb begin
    q_job.radix = radix;
    q_job.bad   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
  end

  assign q_value = items.number;

endmodule

>>> hdl/rde_fifo.sv
// Two-entry job queue between the front end and the back end.
// No package dependencies.
module rde_fifo #(
  parameter int W = 54
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         nonempty
);

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign rdata    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

>>> hdl/rde_back.sv
// Back end: divides the value by the base a byte per cycle, stacks the digits,
// then emits the prefix and the digits most significant first. Uses rde_pkg.
module rde_back import rde_pkg::*; #(
  parameter int VALUE_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  rde_job_t              q_job,
  input  logic [VALUE_BITS-1:0] q_value,
  output logic                  q_pop,
  rde_out_if.source             chars
);

  localparam int CHUNKS_RAW = (VALUE_BITS + 7) / 8;
  localparam int CIDX_W     = (CHUNKS_RAW > 1) ? $clog2(CHUNKS_RAW) : 1;
  localparam int CHUNKS     = 1 << CIDX_W;
  localparam int WB         = CHUNKS * 8;
  localparam int AW         = $clog2(VALUE_BITS);
  localparam int CW         = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_P0   = 3'd4;
  localparam logic [2:0] S_P1   = 3'd5;
  localparam logic [2:0] S_DIG  = 3'd6;

  // Eight restoring steps of long division by a base of at most 16.
  function automatic logic [11:0] div_chunk(input logic [3:0] r_in,
                                            input logic [7:0] d,
                                            input logic [4:0] b);
    logic [4:0] r;
    logic [7:0] q;
    r = {1'b0, r_in};
    q = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      r = {r[3:0], d[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return {r[3:0], q};
  endfunction

  function automatic logic [7:0] glyph(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0, d};
    end
    return CH_A + {4'b0, d} - 8'd10;
  endfunction

  logic [2:0]              state, state_next;
  logic [CHUNKS-1:0][7:0]  work, work_next;
  logic [4:0]              base, base_next;
  logic [3:0]              rem, rem_next;
  logic [CIDX_W-1:0]       cidx, cidx_next;
  logic [CIDX_W-1:0]       top;
  logic [CW-1:0]           cnt, cnt_next;
  logic [AW-1:0]           rd_ptr, rd_ptr_next;
  logic [3:0]              digits [VALUE_BITS];
  logic [3:0]              rd_data;
  logic                    mem_we;
  logic [3:0]              mem_wdata;
  logic [11:0]             dres;
  logic                    out_valid;
  rde_res_t                res, res_next;
  logic                    load;
  logic                    slot_free;

  assign slot_free = !out_valid || chars.ready;
  assign dres      = div_chunk(rem, work[cidx], base);

  // Highest nonzero byte of the remaining quotient; leading zero bytes are skipped.
  always_comb begin
    top = '0;
    for (int i = 0; i < CHUNKS; i++) begin
      if (work[i] != 8'h00) begin
        top = CIDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next  = state;
    work_next   = work;
    base_next   = base;
    rem_next    = rem;
    cidx_next   = cidx;
    cnt_next    = cnt;
    rd_ptr_next = rd_ptr;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = dres[11:8];
    load        = 1'b0;
    res_next    = '0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          base_next  = q_job.radix;
          work_next  = WB'(q_value);
          cnt_next   = '0;
          state_next = q_job.bad ? S_ERR : S_SCAN;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          load                = 1'b1;
          res_next.ascii_char = 8'h00;
          res_next.final_char = 1'b1;
          res_next.bad_radix  = 1'b1;
          state_next          = S_IDLE;
        end
      end
      S_SCAN: begin
        cidx_next  = top;
        rem_next   = 4'h0;
        state_next = S_DIV;
      end
      S_DIV: begin
        work_next[cidx] = dres[7:0];
        rem_next        = dres[11:8];
        if (cidx == '0) begin
          // Remainder is the next digit; stop once the quotient is zero.
          mem_we   = 1'b1;
          cnt_next = cnt + 1'b1;
          if (work_next == '0) begin
            rd_ptr_next = cnt[AW-1:0];
            state_next  = S_P0;
          end else begin
            state_next = S_SCAN;
          end
        end else begin
          cidx_next = cidx - 1'b1;
        end
      end
      S_P0: begin
        if (slot_free) begin
          load                = 1'b1;
          res_next.ascii_char = CH_ZERO;
          state_next          = S_P1;
        end
      end
      S_P1: begin
        if (slot_free) begin
          load                = 1'b1;
          res_next.ascii_char = CH_X;
          state_next          = S_DIG;
        end
      end
      S_DIG: begin
        if (slot_free) begin
          load                = 1'b1;
          res_next.ascii_char = glyph(rd_data);
          res_next.final_char = (rd_ptr == '0);
          if (rd_ptr == '0) begin
            state_next = S_IDLE;
          end else begin
            rd_ptr_next = rd_ptr - 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    work   <= work_next;
    base   <= base_next;
    rem    <= rem_next;
    cidx   <= cidx_next;
    cnt    <= cnt_next;
    rd_ptr <= rd_ptr_next;
    if (load) begin
      res <= res_next;
    end
  end

  // Digit stack; read with the next pointer so rd_data tracks rd_ptr.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digits[cnt[AW-1:0]] <= mem_wdata;
    end
    rd_data <= digits[rd_ptr_next];
  end

  assign chars.valid      = out_valid;
  assign chars.ascii_char = res.ascii_char;
  assign chars.final_char = res.final_char;
  assign chars.bad_radix  = res.bad_radix;

endmodule

>>> hdl/radix_digit_emitter_core.sv
// Top level of the radix digit emitter: base register, front end, job queue
// and back end. Depends on rde_pkg, rde_ifs, rde_front, rde_fifo, rde_back.
//
//   port      dir   payload                              word
//   items     in    number[VALUE_BITS-1:0]               one value to convert
//   chars     out   ascii_char[7:0] final_char bad_radix one text character
//   apb       in    radix at byte address 0               base register
//
// Steps: a value with n digits leaves the queue; then for each digit the
// divider runs over the c bytes of the quotient up to its highest nonzero
// one (at least one), a byte per cycle; then the prefix and the n digits
// are emitted. A bad base gives a single error word.
// Reset is synchronous; the base resets to 16. No clearing pass is needed.
// A stalled chars port holds the back end; the queue keeps taking up to two
// values meanwhile.
`include "assert_macros.svh"

module radix_digit_emitter_core import rde_pkg::*; #(
  parameter int VALUE_BITS = 48
) (
  input  logic              clk,
  input  logic              rst,
  rde_in_if.sink            items,
  rde_out_if.source         chars,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int QW = VALUE_BITS + 6;

  logic [4:0]            radix;
  logic                  radix_hit;
  logic                  q_full;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_nonempty;
  rde_job_t              f_job;
  logic [VALUE_BITS-1:0] f_value;
  logic [QW-1:0]         q_rdata;
  rde_job_t              b_job;
  logic [VALUE_BITS-1:0] b_value;

  assign pready    = 1'b1;
  assign radix_hit = (paddr[ADDR_W-1:2] == REG_RADIX);
  assign prdata    = radix_hit ? {27'b0, radix} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RST;
    end else if (psel && penable && pwrite && radix_hit) begin
      radix <= pwdata[4:0];
    end
  end

  rde_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .items   (items),
    .radix   (radix),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (f_job),
    .q_value (f_value)
  );

  rde_fifo #(.W(QW)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    ({f_job, f_value}),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  assign b_job   = q_rdata[QW-1:VALUE_BITS];
  assign b_value = q_rdata[VALUE_BITS-1:0];

  rde_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_nonempty),
    .q_job   (b_job),
    .q_value (b_value),
    .q_pop   (q_pop),
    .chars   (chars)
  );

  `RDE_ASSERT_IMP(a_err_word, clk, rst, chars.valid && chars.bad_radix,
                  chars.final_char && (chars.ascii_char == 8'h00))
  `RDE_ASSERT_IMP(a_x_not_last, clk, rst, chars.valid && (chars.ascii_char == CH_X),
                  !chars.final_char)
  `RDE_ASSERT_IMP(a_last_is_digit, clk, rst,
                  chars.valid && chars.final_char && !chars.bad_radix,
                  ((chars.ascii_char >= CH_ZERO) && (chars.ascii_char <= CH_NINE)) ||
                  ((chars.ascii_char >= CH_A) && (chars.ascii_char <= CH_F)))
  `RDE_ASSERT_NXT(a_radix_write, clk, rst, psel && penable && pwrite && radix_hit,
                  radix == $past(pwdata[4:0]))

endmodule

>>> sim/rde_char_checker.sv
// Scoreboard for the radix digit emitter: snoops the APB base writes, predicts
// the character words of each accepted value and compares them in order.
// Depends on rde_pkg for the result type, base limits and character codes.
module rde_char_checker import rde_pkg::*; #(
  parameter int VALUE_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_number,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_ascii_char,
  input  logic                  out_final_char,
  input  logic                  out_bad_radix,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output int                    mismatches,
  output int                    chars_pending
);

  logic [4:0] radix_shadow;
  rde_res_t   chars_due [$];

  // Expand one value into its text words: "0x" and the digits, top first, or one error word for a bad base.
  task automatic predict_text(input logic [VALUE_BITS-1:0] value, input logic [4:0] base);
    logic [7:0]      digits [$];
    longint unsigned rest;
    int unsigned     d;
    rde_res_t        w;
    logic [7:0]      glyph;
    if (base < RADIX_MIN || base > RADIX_MAX) begin
      w.ascii_char = 8'h00;
      w.final_char = 1'b1;
      w.bad_radix  = 1'b1;
      chars_due.push_back(w);
      return;
    end
    rest = value;
    do begin
      d = int'(rest % base);
      if (d < 10) glyph = CH_ZERO + 8'(d);
      else glyph = CH_A + 8'(d - 10);
      digits.push_front(glyph);
      rest = rest / base;
    end while (rest != 0);
    w.bad_radix  = 1'b0;
    w.final_char = 1'b0;
    w.ascii_char = CH_ZERO;
    chars_due.push_back(w);
    w.ascii_char = CH_X;
    chars_due.push_back(w);
    foreach (digits[i]) begin
      w.ascii_char = digits[i];
      w.final_char = (i == digits.size() - 1);
      chars_due.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    rde_res_t want;
    if (rst) begin
      radix_shadow = RADIX_RST;
      chars_due.delete();
      mismatches = 0;
    end else begin
      // push before pop so a word leaving in the same cycle still finds its slot
      if (in_valid && in_ready) predict_text(in_number, radix_shadow);
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_RADIX)
        radix_shadow = pwdata[4:0];
      if (out_valid && out_ready) begin
        if (chars_due.size() == 0) begin
          $error("unexpected word: ascii_char %h final_char %b bad_radix %b",
                 out_ascii_char, out_final_char, out_bad_radix);
          mismatches++;
        end else begin
          want = chars_due.pop_front();
          if (out_ascii_char !== want.ascii_char) begin
            $error("ascii_char: expected %h, got %h", want.ascii_char, out_ascii_char);
            mismatches++;
          end
          if (out_final_char !== want.final_char) begin
            $error("final_char: expected %b, got %b", want.final_char, out_final_char);
            mismatches++;
          end
          if (out_bad_radix !== want.bad_radix) begin
            $error("bad_radix: expected %b, got %b", want.bad_radix, out_bad_radix);
            mismatches++;
          end
        end
      end
    end
    chars_pending = chars_due.size();
  end

endmodule

>>> sim/tb_radix_digit_emitter_core.sv
// Testbench top for radix_digit_emitter_core: clock, reset, value and APB
// stimulus, character sink with stalls, and the verdict.
// Depends on rde_pkg, rde_ifs, the core RTL and rde_char_checker.
module tb_radix_digit_emitter_core;
  import rde_pkg::*;

  localparam int                VALUE_BITS  = 48;
  localparam int                CYCLE_LIMIT = 1_000_000;
  localparam logic [ADDR_W-1:0] ADDR_RADIX  = {REG_RADIX, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE  = 3'd4;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int chars_pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_len    = 0;
  int hold_req    = 0;
  int cycles      = 0;

  rde_in_if #(.VALUE_BITS(VALUE_BITS)) items_bus ();
  rde_out_if chars_bus ();

  radix_digit_emitter_core #(.VALUE_BITS(VALUE_BITS)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_bus),
    .chars   (chars_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rde_char_checker #(.VALUE_BITS(VALUE_BITS)) i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (items_bus.valid),
    .in_ready       (items_bus.ready),
    .in_number      (items_bus.number),
    .out_valid      (chars_bus.valid),
    .out_ready      (chars_bus.ready),
    .out_ascii_char (chars_bus.ascii_char),
    .out_final_char (chars_bus.final_char),
    .out_bad_radix  (chars_bus.bad_radix),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatches     (mismatches),
    .chars_pending  (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("radix_digit_emitter_core regression: fail");
        $finish;
      end
    end
  end

  // Character sink: random stalls, plus a long hold-off on request.
  initial begin : char_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    chars_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        chars_bus.ready <= 1'b0;
      end else begin
        chars_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one value; called and returns at a falling edge.
  task automatic offer_number(input logic [VALUE_BITS-1:0] value);
    // keep valid low while the random draw says idle
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      items_bus.valid <= 1'b0;
      @(negedge clk);
    end
    items_bus.valid  <= 1'b1;
    items_bus.number <= value;
    do @(posedge clk); while (!items_bus.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted word has come out.
  task automatic drain_chars();
    items_bus.valid <= 1'b0;
    @(negedge clk);
    while (chars_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_radix(input logic [4:0] base);
    logic [31:0] junk;
    junk = $urandom;
    drain_chars();
    write_reg(ADDR_RADIX, {junk[31:5], base});
  endtask

  function automatic logic [4:0] pick_radix();
    int v;
    if ($urandom_range(0, 99) < 80) return 5'($urandom_range(RADIX_MIN, RADIX_MAX));
    v = $urandom_range(0, 16);
    return (v < 2) ? 5'(v) : 5'(v + 15);
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_number();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return raw[47:0];
      1: return 48'($urandom_range(0, 255));
      2: return {16'h0, raw[31:0]};
      3: return {raw[47:40] | 8'h80, raw[39:0]};
      default: return raw[47:0] >> $urandom_range(0, 47);
    endcase
  endfunction

  task automatic run_phase(input int tx_pct, input int rx_pct, input int n_items);
    int sent;
    int group;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      set_radix(pick_radix());
      group = $urandom_range(3, 8);
      repeat (group) offer_number(pick_number());
      sent += group;
    end
  endtask

  initial begin
    rst              = 1'b1;
    items_bus.valid  = 1'b0;
    items_bus.number = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle_pct = 28;
    rx_idle_pct = 53;

    // reset base is 16
    offer_number(48'h0);
    offer_number(48'hFFFF_FFFF_FFFF);
    offer_number(48'h1);
    offer_number(48'hFEDC_BA98_7654);
    offer_number(48'h0123_4567_89AB);
    // upper write bits are dropped: this sets base 2
    drain_chars();
    write_reg(ADDR_RADIX, 32'hFFFF_FFE2);
    offer_number(48'hFFFF_FFFF_FFFF);
    offer_number(48'h0);
    offer_number(48'h1);
    // unused register index: base stays 2
    drain_chars();
    write_reg(ADDR_SPARE, 32'h0000_0007);
    offer_number(48'h5);
    set_radix(5'd10);
    offer_number(48'd281474976710655);
    offer_number(48'd10);
    offer_number(48'd9);
    set_radix(5'd8);
    offer_number(48'h8000_0000_0000);
    set_radix(5'd3);
    offer_number(48'hFFFF_FFFF_FFFF);
    // out-of-range bases give one error word each
    set_radix(5'd0);
    offer_number(48'h5);
    set_radix(5'd1);
    offer_number(48'h0);
    set_radix(5'd17);
    offer_number(48'd12345);
    set_radix(5'd31);
    offer_number(48'hFFFF_FFFF_FFFF);

    run_phase(28, 53, 30);
    run_phase(53, 28, 30);
    run_phase(0, 0, 20);

    // stall the sink long enough for the queue to fill and back up the input
    set_radix(5'd16);
    hold_len = 400;
    hold_req++;
    repeat (8) offer_number(pick_number());
    drain_chars();
    set_radix(5'd2);
    repeat (6) offer_number(pick_number());

    drain_chars();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("radix_digit_emitter_core regression: pass");
    end else begin
      $display("radix_digit_emitter_core regression: fail");
    end
    $finish;
  end

endmodule
